@@ sv/sfhd_pkg.sv @@
// shared types and constants for the symmetric flow hash dispatcher
package sfhd_pkg;

   localparam logic [31:0] FNV_BASIS  = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME  = 32'd16777619;
   localparam logic [15:0] ETH_VLAN   = 16'h8100;
   localparam logic [15:0] ETH_QINQ   = 16'h88A8;
   localparam logic [15:0] ETH_IPV4   = 16'h0800;
   localparam logic [16:0] POS_MAX    = 17'h1FFFF;
   localparam logic [7:0]  PROTO_TCP  = 8'd6;
   localparam logic [7:0]  PROTO_UDP  = 8'd17;

   localparam logic [1:0]  PATH_TUPLE = 2'd0;
   localparam logic [1:0]  PATH_FRAG  = 2'd1;
   localparam logic [1:0]  PATH_RR    = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MIX,
      ST_DIV_LOAD,
      ST_DIV,
      ST_LOAD
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic take_byte;
      logic eval;
      logic mix;
      logic div_load;
      logic div_step;
      logic load_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic eval_rr;
      logic mix_last;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

@@ sv/sfhd_ctrl.sv @@
// controller: frame capture, hash rounds, divider steps and result hand-off
module sfhd_ctrl import sfhd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last_byte,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.take_byte = req_valid;
            if (req_valid && req_last_byte) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.eval_rr ? ST_DIV : ST_MIX;
         end
         ST_MIX: begin
            cmd.mix = 1'b1;
            if (status.mix_last) begin
               state_in = ST_DIV_LOAD;
            end
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ sv/sfhd_datapath.sv @@
// datapath: header capture, frame checks, fnv-1a rounds, modulo unit, result register
module sfhd_datapath import sfhd_pkg::*; #(
   parameter int MAX_WORKERS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [6:0]  csr_write_data,
   input  logic [7:0]  req_frame_byte,
   input  logic        rsp_ready,
   input  cmd_type     cmd,
   output status_type  status,
   output logic        rsp_valid,
   output logic [5:0]  rsp_worker_index,
   output logic [1:0]  rsp_dispatch_path,
   output logic [31:0] rsp_flow_hash
);

   localparam int WCW = $clog2(MAX_WORKERS + 1);
   localparam int CMW = (WCW > 7) ? WCW : 7;
   localparam logic [CMW-1:0] MAXW_C = CMW'(MAX_WORKERS);

   // configuration and long-lived state
   logic [6:0]  queue_count_ff;
   logic [31:0] rr_count_ff;

   // per-frame capture
   logic [16:0] pos_ff, pos_in;
   logic [15:0] eth_ff, eth_in;
   logic        tag_ff, tag_in;
   logic [7:0]  vihl_ff, vihl_in;
   logic [15:0] tlen_ff, tlen_in;
   logic [7:0]  proto_ff, proto_in;
   logic [15:0] ident_ff, ident_in;
   logic [15:0] fragw_ff, fragw_in;
   logic [31:0] saddr_ff, saddr_in;
   logic [31:0] daddr_ff, daddr_in;
   logic [15:0] sport_ff, sport_in;
   logic [15:0] dport_ff, dport_in;

   // hash and divider
   logic [31:0]    op_ff [4];
   logic [1:0]     mix_cnt_ff;
   logic [31:0]    hash_ff;
   logic [1:0]     path_ff;
   logic [WCW-1:0] wc_ff;
   logic [31:0]    dvd_ff;
   logic [WCW-1:0] rem_ff;
   logic [4:0]     div_cnt_ff;

   // output register
   logic        rsp_valid_ff;
   logic [5:0]  idx_out_ff;
   logic [1:0]  path_out_ff;
   logic [31:0] hash_out_ff;

   // worker count register
   always_ff @(posedge clock) begin
      if (reset) begin
         queue_count_ff <= 7'd1;
      end else if (csr_write_enable) begin
         queue_count_ff <= csr_write_data;
      end
   end

   // byte capture, one byte per beat
   always_comb begin
      logic [16:0] base;
      logic [16:0] off;
      logic [16:0] ihl;
      logic [16:0] koff;
      pos_in   = pos_ff;   eth_in   = eth_ff;   tag_in   = tag_ff;
      vihl_in  = vihl_ff;  tlen_in  = tlen_ff;  proto_in = proto_ff;
      ident_in = ident_ff; fragw_in = fragw_ff; saddr_in = saddr_ff;
      daddr_in = daddr_ff; sport_in = sport_ff; dport_in = dport_ff;
      base = tag_ff ? 17'd18 : 17'd14;
      ihl  = {11'd0, vihl_ff[3:0], 2'b00};
      off  = pos_ff - base;
      koff = off - ihl;
      if (cmd.take_byte) begin
         if (pos_ff == 17'd12) begin
            eth_in[15:8] = req_frame_byte;
         end
         if (pos_ff == 17'd13) begin
            eth_in[7:0] = req_frame_byte;
            if ({eth_ff[15:8], req_frame_byte} == ETH_VLAN ||
                {eth_ff[15:8], req_frame_byte} == ETH_QINQ) begin
               tag_in = 1'b1;
            end
         end else begin
            if (tag_ff && pos_ff == 17'd16) eth_in[15:8] = req_frame_byte;
            if (tag_ff && pos_ff == 17'd17) eth_in[7:0]  = req_frame_byte;
            if (pos_ff >= base) begin
               if (off == 17'd0) begin
                  vihl_in = req_frame_byte;
               end else begin
                  case (off)
                     17'd2:   tlen_in[15:8]  = req_frame_byte;
                     17'd3:   tlen_in[7:0]   = req_frame_byte;
                     17'd4:   ident_in[15:8] = req_frame_byte;
                     17'd5:   ident_in[7:0]  = req_frame_byte;
                     17'd6:   fragw_in[15:8] = req_frame_byte;
                     17'd7:   fragw_in[7:0]  = req_frame_byte;
                     17'd9:   proto_in       = req_frame_byte;
                     default: ;
                  endcase
                  if (off >= 17'd12 && off <= 17'd15) begin
                     saddr_in = {saddr_ff[23:0], req_frame_byte};
                  end
                  if (off >= 17'd16 && off <= 17'd19) begin
                     daddr_in = {daddr_ff[23:0], req_frame_byte};
                  end
                  if (ihl >= 17'd20 && off >= ihl && koff < 17'd4) begin
                     case (koff[1:0])
                        2'd0:    sport_in[15:8] = req_frame_byte;
                        2'd1:    sport_in[7:0]  = req_frame_byte;
                        2'd2:    dport_in[15:8] = req_frame_byte;
                        default: dport_in[7:0]  = req_frame_byte;
                     endcase
                  end
               end
            end
         end
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 17'd1;
         end
      end
      if (cmd.load_out) begin
         pos_in   = '0; eth_in   = '0; tag_in   = 1'b0; vihl_in  = '0;
         tlen_in  = '0; proto_in = '0; ident_in = '0; fragw_in = '0;
         saddr_in = '0; daddr_in = '0; sport_in = '0; dport_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0; eth_ff   <= '0; tag_ff   <= 1'b0; vihl_ff  <= '0;
         tlen_ff  <= '0; proto_ff <= '0; ident_ff <= '0; fragw_ff <= '0;
         saddr_ff <= '0; daddr_ff <= '0; sport_ff <= '0; dport_ff <= '0;
      end else begin
         pos_ff   <= pos_in;   eth_ff   <= eth_in;   tag_ff   <= tag_in;
         vihl_ff  <= vihl_in;  tlen_ff  <= tlen_in;  proto_ff <= proto_in;
         ident_ff <= ident_in; fragw_ff <= fragw_in; saddr_ff <= saddr_in;
         daddr_ff <= daddr_in; sport_ff <= sport_in; dport_ff <= dport_in;
      end
   end

   // frame checks and path choice
   logic [16:0]    n_rem, ihl17, tl17;
   logic           hdr_ok, is_frag, path_tuple, path_frag, swap_tuple, swap_addr;
   logic [1:0]     path_sel;
   logic [CMW-1:0] wc_wide;
   logic [WCW-1:0] wc_clamp;

   always_comb begin
      ihl17 = {11'd0, vihl_ff[3:0], 2'b00};
      tl17  = {1'b0, tlen_ff};
      n_rem = (pos_ff >= 17'd18) ? (pos_ff - 17'd14 - (tag_ff ? 17'd4 : 17'd0)) : 17'd0;
      hdr_ok = pos_ff >= 17'd34 && eth_ff == ETH_IPV4 && n_rem >= 17'd20 &&
               vihl_ff[7:4] == 4'd4 && ihl17 >= 17'd20 && ihl17 <= n_rem &&
               tl17 >= ihl17 && tl17 <= n_rem &&
               (proto_ff == PROTO_TCP || proto_ff == PROTO_UDP);
      is_frag    = fragw_ff[13] || (fragw_ff[12:0] != 13'd0);
      path_tuple = hdr_ok && !is_frag && (tl17 - ihl17 >= 17'd8);
      path_frag  = hdr_ok && is_frag;
      path_sel   = path_tuple ? PATH_TUPLE : (path_frag ? PATH_FRAG : PATH_RR);
      swap_tuple = saddr_ff > daddr_ff || (saddr_ff == daddr_ff && sport_ff > dport_ff);
      swap_addr  = saddr_ff > daddr_ff;
      wc_wide    = CMW'(queue_count_ff);
      wc_clamp   = (wc_wide > MAXW_C) ? WCW'(MAXW_C) : WCW'(wc_wide);
   end

   // hash operands, fnv-1a rounds and the modulo unit
   logic [WCW:0] rem_shift;
   always_comb begin
      rem_shift = {rem_ff, dvd_ff[31]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rr_count_ff <= '0;
         mix_cnt_ff  <= '0;
         div_cnt_ff  <= '0;
      end else begin
         if (cmd.eval) begin
            mix_cnt_ff <= '0;
            div_cnt_ff <= '0;
            if (path_sel == PATH_RR && wc_clamp != '0) begin
               rr_count_ff <= rr_count_ff + 32'd1;
            end
         end
         if (cmd.mix) mix_cnt_ff <= mix_cnt_ff + 2'd1;
         if (cmd.div_step) div_cnt_ff <= div_cnt_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         path_ff <= path_sel;
         wc_ff   <= wc_clamp;
         hash_ff <= FNV_BASIS;
         dvd_ff  <= rr_count_ff;
         rem_ff  <= '0;
         if (path_tuple) begin
            op_ff[0] <= swap_tuple ? daddr_ff : saddr_ff;
            op_ff[1] <= swap_tuple ? saddr_ff : daddr_ff;
            op_ff[2] <= swap_tuple ? {dport_ff, sport_ff} : {sport_ff, dport_ff};
         end else begin
            op_ff[0] <= swap_addr ? daddr_ff : saddr_ff;
            op_ff[1] <= swap_addr ? saddr_ff : daddr_ff;
            op_ff[2] <= {16'd0, ident_ff};
         end
         op_ff[3] <= {24'd0, proto_ff};
      end
      if (cmd.mix) begin
         hash_ff <= (hash_ff ^ op_ff[mix_cnt_ff]) * FNV_PRIME;
      end
      if (cmd.div_load) begin
         dvd_ff <= hash_ff;
         rem_ff <= '0;
      end
      // restoring division, one quotient bit a cycle
      if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[30:0], 1'b0};
         if (rem_shift >= {1'b0, wc_ff}) begin
            rem_ff <= WCW'(rem_shift - {1'b0, wc_ff});
         end else begin
            rem_ff <= WCW'(rem_shift);
         end
      end
   end

   // result register
   logic [WCW+5:0] idx_ext;
   always_comb begin
      idx_ext = {6'd0, rem_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         idx_out_ff  <= (wc_ff == '0) ? 6'd0 : idx_ext[5:0];
         path_out_ff <= path_ff;
         hash_out_ff <= (path_ff == PATH_RR) ? 32'd0 : hash_ff;
      end
   end

   assign status.eval_rr  = (path_sel == PATH_RR);
   assign status.mix_last = (mix_cnt_ff == 2'd3);
   assign status.div_last = (div_cnt_ff == 5'd31);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_worker_index  = idx_out_ff;
   assign rsp_dispatch_path = path_out_ff;
   assign rsp_flow_hash     = hash_out_ff;

endmodule

@@ sv/symmetric_flow_hash_dispatcher.sv @@
// top level of the symmetric flow hash dispatcher
//
// Frame bytes enter on the req_ channel, one byte per beat, with req_last_byte
// marking the final byte. Bytes of a frame are taken back to back, one a cycle.
// After the last byte req_ready drops while the block checks the IPv4 header,
// runs the four fnv-1a rounds (one 32x32 multiply a cycle) on the hashed paths
// and reduces the hash, or on the round-robin path the round-robin counter,
// modulo the worker count in a restoring divider, one bit a cycle. The result
// beat (worker index, path, hash) is loaded on rsp_ once the divider's 32
// steps are done. req_ready returns the cycle after the result is loaded, so
// the next frame streams in while the result waits. If rsp_ready is held low,
// a further finished frame waits before its result is loaded and req_ready
// stays low until the old result is taken.
// csr_write_enable writes the worker queue count (reset value 1) and is meant
// for idle periods. Reset clears the capture state, the round-robin counter
// and the result valid flag; no clearing pass is needed.
module symmetric_flow_hash_dispatcher import sfhd_pkg::*; #(
   parameter int MAX_WORKERS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [6:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_worker_index,
   output logic [1:0]  rsp_dispatch_path,
   output logic [31:0] rsp_flow_hash
);

   cmd_type    cmd;
   status_type status;

   // control
   sfhd_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_byte (req_last_byte),
      .req_ready     (req_ready),
      .status        (status),
      .cmd           (cmd)
   );

   // datapath
   sfhd_datapath #(
      .MAX_WORKERS (MAX_WORKERS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_frame_byte    (req_frame_byte),
      .rsp_ready         (rsp_ready),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_worker_index  (rsp_worker_index),
      .rsp_dispatch_path (rsp_dispatch_path),
      .rsp_flow_hash     (rsp_flow_hash)
   );

   // a last byte stops intake until its result is loaded
   a_last_stops_intake: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last_byte) |=> !req_ready)
      else $error("intake not stopped after last byte");

   // round-robin results carry no hash
   a_rr_zero_hash: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dispatch_path == PATH_RR) |-> (rsp_flow_hash == 32'd0))
      else $error("round-robin result with nonzero hash");

   // path code is one of the three defined ones
   a_path_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_dispatch_path == PATH_TUPLE ||
                     rsp_dispatch_path == PATH_FRAG || rsp_dispatch_path == PATH_RR))
      else $error("undefined dispatch path");

   // index stays below the worker limit
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_worker_index) < MAX_WORKERS))
      else $error("worker index out of range");

endmodule
